// ===== hdl/lsms_pkg.sv =====
// ---------------------------------------------------------------------------
// LCD scanline mode sequencer package
// Shared widths, constants, line classes and the per-line record.
// ---------------------------------------------------------------------------
package lsms_pkg;

  localparam int unsigned LINES_PER_FRAME_DEFAULT = 154;

  localparam int unsigned LINE_W    = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CYCLES_W  = 9;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  // Register indices on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_LCD_ENABLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAT_IRQ_EN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SKIP   = 8'd3;

  // Display modes.
  localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

  // Status interrupt enable bits.
  localparam int unsigned EN_HBLANK = 0;
  localparam int unsigned EN_VBLANK = 1;
  localparam int unsigned EN_OAM    = 2;
  localparam int unsigned EN_COINC  = 3;

  localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE  = 8'd144;
  localparam logic [LINE_W-1:0] SATURATE_COUNT     = 8'd255;
  // Line counter value after reset, so that the first tick lands on line zero.
  localparam logic [LINE_W-1:0] LINE_COUNTER_RESET = 8'd153;

  // Phase budgets in machine cycles.
  localparam logic [CYCLES_W-1:0] CYC_FULL_LINE = 9'd456;
  localparam logic [CYCLES_W-1:0] CYC_OAM       = 9'd80;
  localparam logic [CYCLES_W-1:0] CYC_TRANSFER  = 9'd169;
  localparam logic [CYCLES_W-1:0] CYC_HBLANK    = 9'd207;
  localparam logic [CYCLES_W-1:0] CYC_VBL_ENTRY = 9'd72;
  localparam logic [CYCLES_W-1:0] CYC_VBL_TAIL  = 9'd376;

  // Class of a scanline, which fixes its sequence of phases.
  typedef enum logic [2:0] {
    KIND_OFF,
    KIND_VISIBLE,
    KIND_VBL_FIRST,
    KIND_VBL_FINAL,
    KIND_VBL_MID
  } line_kind_t;

  typedef struct packed {
    line_kind_t        kind;
    logic [LINE_W-1:0] line;
    logic              coinc;
    logic              coinc_irq;
    logic              present;
    logic              blank;
    logic              render;
    logic              dma;
  } line_rec_t;

  // Index of the final phase of a line of the given class.
  function automatic logic [1:0] last_phase(line_kind_t kind);
    logic [1:0] res;
    case (kind)
      KIND_VISIBLE:   res = 2'd2;
      KIND_VBL_FIRST: res = 2'd1;
      KIND_VBL_FINAL: res = 2'd1;
      default:        res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/lsms_if.sv =====
// ---------------------------------------------------------------------------
// LCD scanline mode sequencer channels
// Valid/ready interfaces for scanline ticks, phase results and register
// writes.
// ---------------------------------------------------------------------------
interface lsms_tick_if;
  logic valid;
  logic ready;
  logic hblank_dma_active;

  modport source (output valid, output hblank_dma_active, input ready);
  modport sink (input valid, input hblank_dma_active, output ready);
endinterface

interface lsms_phase_if;
  logic                                valid;
  logic                                ready;
  logic [lsms_pkg::LINE_W-1:0]         line;
  logic [lsms_pkg::MODE_W-1:0]         mode;
  logic                                coincidence;
  logic                                stat_irq;
  logic                                vblank_irq;
  logic [lsms_pkg::CYCLES_W-1:0]       phase_cycles;
  logic                                render_line;
  logic                                dma_block;
  logic                                present_frame;
  logic                                blank_frame;
  logic                                last;

  modport source (output valid, output line, output mode, output coincidence,
                  output stat_irq, output vblank_irq, output phase_cycles,
                  output render_line, output dma_block, output present_frame,
                  output blank_frame, output last, input ready);
  modport sink (input valid, input line, input mode, input coincidence,
                input stat_irq, input vblank_irq, input phase_cycles,
                input render_line, input dma_block, input present_frame,
                input blank_frame, input last, output ready);
endinterface

interface lsms_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lsms_pkg::CFG_IDX_W-1:0]     index;
  logic [lsms_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lcd_scanline_mode_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// LCD scanline mode sequencer
// Turns scanline ticks into the timed phases of an LCD line.
// ---------------------------------------------------------------------------
// Each transfer on the tick channel is one scanline. On acceptance the line
// counter advances (modulo LINES_PER_FRAME), the coincidence compare, frame
// skip decision and blank-frame counting are done, and a one-line record is
// written into an input register. That record moves into the result
// register, which emits the line's phases one per cycle while the phase
// channel is ready: three for a visible line (OAM scan, pixel transfer,
// hblank), two for the first vblank line and for the final line, and one
// for other vblank lines or while the display is off. The last phase of a
// line carries the last flag. The input register takes the next tick while
// the current line's phases are still being delivered, so no cycle is lost
// between lines. Register writes are always accepted and must be made while
// the block is idle; writes to an index outside the register list are
// ignored.
// ---------------------------------------------------------------------------
module lcd_scanline_mode_sequencer_top #(
  parameter int unsigned LINES_PER_FRAME = lsms_pkg::LINES_PER_FRAME_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  lsms_tick_if.sink    tick,
  lsms_phase_if.source phase,
  lsms_cfg_if.sink     cfg
);

  localparam logic [lsms_pkg::LINE_W:0]   LPF_EXT    =
    (lsms_pkg::LINE_W+1)'(LINES_PER_FRAME);
  localparam logic [lsms_pkg::LINE_W-1:0] LPF_LINE   =
    lsms_pkg::LINE_W'(LINES_PER_FRAME);
  localparam logic [lsms_pkg::LINE_W-1:0] FINAL_LINE =
    lsms_pkg::LINE_W'(LINES_PER_FRAME - 1);

  // Configuration registers.
  logic                          lcd_enable;
  logic [lsms_pkg::LINE_W-1:0]   line_compare;
  logic [3:0]                    stat_irq_enables;
  logic [lsms_pkg::LINE_W-1:0]   frame_skip;

  // Sequencer state.
  logic [lsms_pkg::LINE_W-1:0]   line_counter;
  logic [lsms_pkg::LINE_W-1:0]   frames_since_shown;
  logic [lsms_pkg::LINE_W-1:0]   active_skip;
  logic [lsms_pkg::LINE_W-1:0]   lines_while_off;

  logic [lsms_pkg::LINE_W-1:0]   line_counter_next;
  logic [lsms_pkg::LINE_W-1:0]   frames_since_shown_next;
  logic [lsms_pkg::LINE_W-1:0]   active_skip_next;
  logic [lsms_pkg::LINE_W-1:0]   lines_while_off_next;

  // Input register and result register.
  logic                  a_valid;
  lsms_pkg::line_rec_t   a_rec;
  lsms_pkg::line_rec_t   a_rec_next;
  logic                  b_valid;
  lsms_pkg::line_rec_t   b_rec;
  logic [1:0]            b_phase;

  logic accept;
  logic b_last;
  logic b_free;
  logic a_to_b;

  logic [lsms_pkg::LINE_W:0]   line_inc;
  logic [lsms_pkg::LINE_W-1:0] line_new;
  logic [lsms_pkg::LINE_W-1:0] off_count;
  logic                        decide;
  logic                        show;

  assign cfg.ready = 1'b1;

  assign b_last = (b_phase == lsms_pkg::last_phase(b_rec.kind));
  assign b_free = !b_valid || (phase.ready && b_last);
  assign a_to_b = a_valid && b_free;
  assign tick.ready = !a_valid || b_free;
  assign accept = tick.valid && tick.ready;

  // Per-line decisions, made once when the tick is accepted.
  always_comb begin
    line_inc  = {1'b0, line_counter} + 9'd1;
    line_new  = (line_inc >= LPF_EXT) ? lsms_pkg::LINE_W'(line_inc - LPF_EXT)
                                      : line_inc[lsms_pkg::LINE_W-1:0];
    off_count = lines_while_off + 8'd1;

    line_counter_next       = line_counter;
    frames_since_shown_next = frames_since_shown;
    active_skip_next        = active_skip;
    lines_while_off_next    = lines_while_off;

    a_rec_next           = '0;
    a_rec_next.dma       = tick.hblank_dma_active;

    if (!lcd_enable) begin
      line_counter_next    = '0;
      decide               = (off_count >= LPF_LINE);
      lines_while_off_next = decide ? '0 : off_count;
      a_rec_next.kind      = lsms_pkg::KIND_OFF;
      a_rec_next.blank     = decide;
    end else begin
      line_counter_next    = line_new;
      decide               = (line_new == '0);
      a_rec_next.line      = line_new;
      a_rec_next.coinc     = (line_new == line_compare);
      a_rec_next.coinc_irq = a_rec_next.coinc &&
                             stat_irq_enables[lsms_pkg::EN_COINC];
      if (decide) begin
        active_skip_next = frame_skip;
      end
      if (line_new < lsms_pkg::FIRST_VBLANK_LINE) begin
        a_rec_next.kind = lsms_pkg::KIND_VISIBLE;
      end else if (line_new == lsms_pkg::FIRST_VBLANK_LINE) begin
        a_rec_next.kind = lsms_pkg::KIND_VBL_FIRST;
      end else if (line_new == FINAL_LINE) begin
        a_rec_next.kind = lsms_pkg::KIND_VBL_FINAL;
      end else begin
        a_rec_next.kind = lsms_pkg::KIND_VBL_MID;
      end
    end

    // Frame decision: present when enough frames have been skipped,
    // otherwise count the skipped frame (saturating).
    show = (frames_since_shown >= active_skip);
    if (decide) begin
      a_rec_next.present = show;
      if (show) begin
        frames_since_shown_next = '0;
      end else if (frames_since_shown != lsms_pkg::SATURATE_COUNT) begin
        frames_since_shown_next = frames_since_shown + 8'd1;
      end
    end
    a_rec_next.render = (frames_since_shown_next >= active_skip_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_enable         <= 1'b1;
      line_compare       <= '0;
      stat_irq_enables   <= '0;
      frame_skip         <= '0;
      line_counter       <= lsms_pkg::LINE_COUNTER_RESET;
      frames_since_shown <= '0;
      active_skip        <= '0;
      lines_while_off    <= '0;
      a_valid            <= 1'b0;
      b_valid            <= 1'b0;
      b_phase            <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          lsms_pkg::REG_LCD_ENABLE:   lcd_enable       <= cfg.data[0];
          lsms_pkg::REG_LINE_COMPARE: line_compare     <= cfg.data;
          lsms_pkg::REG_STAT_IRQ_EN:  stat_irq_enables <= cfg.data[3:0];
          lsms_pkg::REG_FRAME_SKIP:   frame_skip       <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        line_counter       <= line_counter_next;
        frames_since_shown <= frames_since_shown_next;
        active_skip        <= active_skip_next;
        lines_while_off    <= lines_while_off_next;
        a_valid            <= 1'b1;
      end else if (a_to_b) begin
        a_valid <= 1'b0;
      end
      if (a_to_b) begin
        b_valid <= 1'b1;
        b_phase <= '0;
      end else if (b_valid && phase.ready) begin
        if (b_last) begin
          b_valid <= 1'b0;
        end else begin
          b_phase <= b_phase + 2'd1;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_rec <= a_rec_next;
    end
    if (a_to_b) begin
      b_rec <= a_rec;
    end
  end

  // Phase decode from the line record and the phase index.
  always_comb begin
    phase.valid         = b_valid;
    phase.last          = b_last;
    phase.line          = b_rec.line;
    phase.mode          = lsms_pkg::MODE_VBLANK;
    phase.coincidence   = b_rec.coinc;
    phase.stat_irq      = 1'b0;
    phase.vblank_irq    = 1'b0;
    phase.phase_cycles  = lsms_pkg::CYC_FULL_LINE;
    phase.render_line   = 1'b0;
    phase.dma_block     = 1'b0;
    phase.present_frame = (b_phase == 2'd0) ? b_rec.present : 1'b0;
    phase.blank_frame   = 1'b0;
    case (b_rec.kind)
      lsms_pkg::KIND_OFF: begin
        phase.line        = '0;
        phase.mode        = lsms_pkg::MODE_HBLANK;
        phase.coincidence = 1'b0;
        phase.blank_frame = b_rec.blank;
      end
      lsms_pkg::KIND_VISIBLE: begin
        case (b_phase)
          2'd0: begin
            phase.mode         = lsms_pkg::MODE_OAM;
            phase.stat_irq     = b_rec.coinc_irq ||
                                 stat_irq_enables[lsms_pkg::EN_OAM];
            phase.phase_cycles = lsms_pkg::CYC_OAM;
          end
          2'd1: begin
            phase.mode         = lsms_pkg::MODE_TRANSFER;
            phase.phase_cycles = lsms_pkg::CYC_TRANSFER;
          end
          default: begin
            phase.mode         = lsms_pkg::MODE_HBLANK;
            phase.phase_cycles = lsms_pkg::CYC_HBLANK;
            phase.render_line  = b_rec.render;
            phase.dma_block    = b_rec.dma;
            phase.stat_irq     = !b_rec.dma && stat_irq_enables[lsms_pkg::EN_HBLANK];
          end
        endcase
      end
      lsms_pkg::KIND_VBL_FIRST: begin
        if (b_phase == 2'd0) begin
          phase.stat_irq     = b_rec.coinc_irq;
          phase.phase_cycles = lsms_pkg::CYC_VBL_ENTRY;
        end else begin
          phase.stat_irq     = stat_irq_enables[lsms_pkg::EN_VBLANK];
          phase.vblank_irq   = 1'b1;
          phase.phase_cycles = lsms_pkg::CYC_VBL_TAIL;
        end
      end
      lsms_pkg::KIND_VBL_FINAL: begin
        if (b_phase == 2'd0) begin
          phase.stat_irq     = b_rec.coinc_irq;
          phase.phase_cycles = lsms_pkg::CYC_OAM;
        end else begin
          // The tail of the final line already reports line zero.
          phase.line         = '0;
          phase.phase_cycles = lsms_pkg::CYC_VBL_TAIL;
        end
      end
      default: begin
        phase.stat_irq = b_rec.coinc_irq;
      end
    endcase
  end

  // A visible-line record must carry a line below the vblank boundary.
  assert property (@(posedge clk) disable iff (rst)
    b_valid && b_rec.kind == lsms_pkg::KIND_VISIBLE |->
      b_rec.line < lsms_pkg::FIRST_VBLANK_LINE)
    else $error("visible line record beyond the first vblank line");

  // The phase index never passes the final phase of its line.
  assert property (@(posedge clk) disable iff (rst)
    b_valid |-> b_phase <= lsms_pkg::last_phase(b_rec.kind))
    else $error("phase index beyond the last phase of the line");

  // An empty result register always lets a tick in.
  assert property (@(posedge clk) disable iff (rst)
    !b_valid |-> tick.ready)
    else $error("tick stalled while the result register is empty");

  // The display-off line count stays below one frame.
  assert property (@(posedge clk) disable iff (rst)
    lines_while_off < LPF_LINE)
    else $error("display-off line count reached a whole frame");

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// LCD scanline mode sequencer testbench
// Sends scanline ticks through the block under a range of register
// settings, predicts the phases of every line and checks each phase result
// field by field, in order, under random idling on both channels.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LINES  = lsms_pkg::LINES_PER_FRAME_DEFAULT;
  // Cycles without any transfer on any channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT  = 1000;
  // Quiet cycles after the last expected phase, to catch stray results.
  localparam int unsigned TAIL_CYCLES  = 8;

  // One expected phase result, laid out as the phase channel carries it.
  typedef struct packed {
    logic [lsms_pkg::LINE_W-1:0]   line;
    logic [lsms_pkg::MODE_W-1:0]   mode;
    logic                          coincidence;
    logic                          stat_irq;
    logic                          vblank_irq;
    logic [lsms_pkg::CYCLES_W-1:0] phase_cycles;
    logic                          render_line;
    logic                          dma_block;
    logic                          present_frame;
    logic                          blank_frame;
    logic                          last;
  } phase_rec_t;

  logic clk;
  logic rst;

  lsms_tick_if  tick();
  lsms_phase_if phase();
  lsms_cfg_if   cfg();

  lcd_scanline_mode_sequencer_top u_top (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .phase (phase),
    .cfg   (cfg)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // -------------------------------------------------------------------------
  // Predictor state. The register copies follow every accepted write; the
  // line and frame counters follow every accepted tick.
  // -------------------------------------------------------------------------
  logic       lcd_on;
  logic [7:0] lyc;
  logic [3:0] irq_en;
  logic [7:0] skip_cfg;

  logic [7:0] cur_line;
  logic [7:0] frames_waited;
  logic [7:0] skip_latched;
  logic [7:0] off_count;

  // Ticks still to be sent (each entry is the hblank DMA request of a line)
  // and the phases that the block still owes us, oldest first.
  logic       tick_pending_q[$];
  phase_rec_t phase_expect_q[$];

  int unsigned error_count;
  int unsigned stall_cycles;
  bit          tick_taken;   // the tick on the channel went at the last edge
  bit          steady;       // no idling on either side while set

  function automatic phase_rec_t make_phase(
    input logic [7:0] ln, input logic [1:0] md, input logic co,
    input logic si, input logic vi, input logic [8:0] cyc, input logic rl,
    input logic db, input logic pf, input logic bf, input logic lst);
    phase_rec_t r;
    r.line          = ln;
    r.mode          = md;
    r.coincidence   = co;
    r.stat_irq      = si;
    r.vblank_irq    = vi;
    r.phase_cycles  = cyc;
    r.render_line   = rl;
    r.dma_block     = db;
    r.present_frame = pf;
    r.blank_frame   = bf;
    r.last          = lst;
    return r;
  endfunction

  // Frame decision: present once enough frames have been held back,
  // otherwise count one more held-back frame, saturating.
  function automatic logic decide_present();
    if (frames_waited >= skip_latched) begin
      frames_waited = 8'd0;
      return 1'b1;
    end
    if (frames_waited != lsms_pkg::SATURATE_COUNT) frames_waited = frames_waited + 8'd1;
    return 1'b0;
  endfunction

  // Works out the phases of one accepted scanline tick and queues them.
  task automatic advance_scanline(input logic dma);
    int unsigned nxt;
    logic [7:0]  ln;
    logic        co;
    logic        ci;
    logic        pf;
    logic        bf;
    logic        rl;
    pf = 1'b0;
    bf = 1'b0;
    if (!lcd_on) begin
      // With the display off the line stays at zero and a white frame goes
      // out once a whole frame's worth of lines has passed.
      cur_line  = 8'd0;
      off_count = off_count + 8'd1;
      if (off_count >= FRAME_LINES) begin
        bf        = 1'b1;
        pf        = decide_present();
        off_count = 8'd0;
      end
      phase_expect_q.push_back(make_phase(8'd0, lsms_pkg::MODE_HBLANK, 1'b0, 1'b0,
                                          1'b0, lsms_pkg::CYC_FULL_LINE, 1'b0, 1'b0,
                                          pf, bf, 1'b1));
    end else begin
      nxt      = (cur_line + 1) % FRAME_LINES;
      ln       = nxt[7:0];
      cur_line = ln;
      co       = (ln == lyc);
      ci       = co & irq_en[lsms_pkg::EN_COINC];
      if (ln == 8'd0) begin
        pf           = decide_present();
        skip_latched = skip_cfg;
      end
      if (ln == lsms_pkg::FIRST_VBLANK_LINE) begin
        phase_expect_q.push_back(make_phase(ln, lsms_pkg::MODE_VBLANK, co, ci, 1'b0,
                                            lsms_pkg::CYC_VBL_ENTRY, 1'b0, 1'b0, pf,
                                            1'b0, 1'b0));
        phase_expect_q.push_back(make_phase(ln, lsms_pkg::MODE_VBLANK, co,
                                            irq_en[lsms_pkg::EN_VBLANK], 1'b1,
                                            lsms_pkg::CYC_VBL_TAIL, 1'b0, 1'b0, 1'b0,
                                            1'b0, 1'b1));
      end else if (ln == FRAME_LINES - 1) begin
        // The final line already reports line zero in its long second phase,
        // but keeps its own coincidence flag.
        phase_expect_q.push_back(make_phase(ln, lsms_pkg::MODE_VBLANK, co, ci, 1'b0,
                                            lsms_pkg::CYC_OAM, 1'b0, 1'b0, pf, 1'b0,
                                            1'b0));
        phase_expect_q.push_back(make_phase(8'd0, lsms_pkg::MODE_VBLANK, co, 1'b0,
                                            1'b0, lsms_pkg::CYC_VBL_TAIL, 1'b0, 1'b0,
                                            1'b0, 1'b0, 1'b1));
      end else if (ln > lsms_pkg::FIRST_VBLANK_LINE) begin
        phase_expect_q.push_back(make_phase(ln, lsms_pkg::MODE_VBLANK, co, ci, 1'b0,
                                            lsms_pkg::CYC_FULL_LINE, 1'b0, 1'b0, pf,
                                            1'b0, 1'b1));
      end else begin
        rl = (frames_waited >= skip_latched);
        phase_expect_q.push_back(make_phase(ln, lsms_pkg::MODE_OAM, co,
                                            ci | irq_en[lsms_pkg::EN_OAM], 1'b0,
                                            lsms_pkg::CYC_OAM, 1'b0, 1'b0, pf, 1'b0,
                                            1'b0));
        phase_expect_q.push_back(make_phase(ln, lsms_pkg::MODE_TRANSFER, co, 1'b0,
                                            1'b0, lsms_pkg::CYC_TRANSFER, 1'b0, 1'b0,
                                            1'b0, 1'b0, 1'b0));
        // An hblank DMA line moves a block and holds back the hblank request.
        phase_expect_q.push_back(make_phase(ln, lsms_pkg::MODE_HBLANK, co,
                                            dma ? 1'b0 : irq_en[lsms_pkg::EN_HBLANK],
                                            1'b0, lsms_pkg::CYC_HBLANK, rl, dma, 1'b0,
                                            1'b0, 1'b1));
      end
    end
  endtask

  // Register writes keep only the bits each register holds; unknown indexes
  // change nothing.
  task automatic apply_reg(input logic [7:0] idx, input logic [7:0] data);
    case (idx)
      lsms_pkg::REG_LCD_ENABLE:   lcd_on   = data[0];
      lsms_pkg::REG_LINE_COMPARE: lyc      = data;
      lsms_pkg::REG_STAT_IRQ_EN:  irq_en   = data[3:0];
      lsms_pkg::REG_FRAME_SKIP:   skip_cfg = data;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, name, want, got);
    end
  endtask

  // -------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, where the inputs set
  // up at the previous falling edge are stable and the block's outputs still
  // hold the values of the cycle that is ending. Register writes and ticks
  // are folded into the predictor before the phase result of the same edge
  // is compared, so the order of the checks never depends on the scheduler.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    phase_rec_t want;
    bit         moved;
    if (rst === 1'b0) begin
      moved = 1'b0;
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        apply_reg(cfg.index, cfg.data);
        moved = 1'b1;
      end
      if (tick.valid === 1'b1 && tick.ready === 1'b1) begin
        advance_scanline(tick.hblank_dma_active);
        void'(tick_pending_q.pop_front());
        tick_taken = 1'b1;
        moved      = 1'b1;
      end
      if (phase.valid === 1'b1 && phase.ready === 1'b1) begin
        moved = 1'b1;
        if (phase_expect_q.size() == 0) begin
          error_count++;
          $display({"%0t ns: phase result with nothing expected, expected none, ",
                    "actual line %0d mode %0d cycles %0d"},
                   $time, phase.line, phase.mode, phase.phase_cycles);
        end else begin
          want = phase_expect_q.pop_front();
          check_field("line",          9'(want.line),          9'(phase.line));
          check_field("mode",          9'(want.mode),          9'(phase.mode));
          check_field("coincidence",   9'(want.coincidence),   9'(phase.coincidence));
          check_field("stat_irq",      9'(want.stat_irq),      9'(phase.stat_irq));
          check_field("vblank_irq",    9'(want.vblank_irq),    9'(phase.vblank_irq));
          check_field("phase_cycles",  want.phase_cycles,      phase.phase_cycles);
          check_field("render_line",   9'(want.render_line),   9'(phase.render_line));
          check_field("dma_block",     9'(want.dma_block),     9'(phase.dma_block));
          check_field("present_frame", 9'(want.present_frame), 9'(phase.present_frame));
          check_field("blank_frame",   9'(want.blank_frame),   9'(phase.blank_frame));
          check_field("last",          9'(want.last),          9'(phase.last));
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Driver. Inputs change only at the falling edge. A tick on the channel is
  // held until its transfer has happened; otherwise the next pending tick is
  // offered unless this cycle is an idle one, in which case the DMA bit is
  // left to wander so that nothing depends on it while valid is low. The
  // phase channel's ready is dropped in about one cycle in five.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst !== 1'b0) begin
      tick.valid             <= 1'b0;
      tick.hblank_dma_active <= 1'b0;
      phase.ready            <= 1'b0;
    end else begin
      if (tick.valid === 1'b1 && !tick_taken) begin
        // Still waiting for this transfer: leave the channel as it is.
      end else if (tick_pending_q.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
        tick.valid             <= 1'b1;
        tick.hblank_dma_active <= tick_pending_q[0];
      end else begin
        tick.valid             <= 1'b0;
        tick.hblank_dma_active <= 1'($urandom_range(1));
      end
      tick_taken = 1'b0;
      phase.ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // One register write, made at the falling edge and held until the
  // transfer; valid then drops at the following falling edge.
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Waits until every tick has gone and every phase it caused has arrived.
  // The block is then idle, since every tick yields at least one phase.
  task automatic drain();
    while (tick_pending_q.size() != 0 || phase_expect_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_lines(input int unsigned count, input bit no_idle);
    repeat (count) tick_pending_q.push_back(1'($urandom_range(1)));
    steady = no_idle;
    drain();
    steady = 1'b0;
  endtask

  // A fresh random setting of all four registers. The compare value mostly
  // lands on a line coming up soon, so that coincidence actually happens.
  task automatic shuffle_regs(input bit force_on);
    logic [7:0]  v;
    int unsigned k;
    v    = 8'($urandom);
    v[0] = force_on || ($urandom_range(99) < 80);
    write_reg(lsms_pkg::REG_LCD_ENABLE, v);
    if ($urandom_range(99) < 70) begin
      k = (cur_line + $urandom_range(1, 20)) % FRAME_LINES;
      v = k[7:0];
    end else begin
      v = 8'($urandom);
    end
    write_reg(lsms_pkg::REG_LINE_COMPARE, v);
    v = 8'($urandom);
    write_reg(lsms_pkg::REG_STAT_IRQ_EN, v);
    case ($urandom_range(3))
      0:       v = 8'd0;
      1:       v = 8'($urandom_range(1, 3));
      2:       v = 8'd255;
      default: v = 8'($urandom);
    endcase
    write_reg(lsms_pkg::REG_FRAME_SKIP, v);
    if ($urandom_range(99) < 30) begin
      k = $urandom_range(4, 255);
      v = 8'($urandom);
      write_reg(k[7:0], v);
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus and end of run.
  // -------------------------------------------------------------------------
  initial begin : stimulus
    lcd_on        = 1'b1;
    lyc           = 8'd0;
    irq_en        = 4'd0;
    skip_cfg      = 8'd0;
    cur_line      = lsms_pkg::LINE_COUNTER_RESET;
    frames_waited = 8'd0;
    skip_latched  = 8'd0;
    off_count     = 8'd0;
    error_count   = 0;
    stall_cycles  = 0;
    tick_taken    = 1'b0;
    steady        = 1'b0;

    rst                    = 1'b1;
    tick.valid             = 1'b0;
    tick.hblank_dma_active = 1'b0;
    phase.ready            = 1'b0;
    cfg.valid              = 1'b0;
    cfg.index              = 8'd0;
    cfg.data               = 8'd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The counter comes out of reset on the final line, so
    // the first tick is line zero: a frame is presented there and a skip of
    // one is latched, which makes the rest of that frame a skipped one with
    // render_line low. Every status interrupt is enabled (the upper bits of
    // the write must be dropped) and the compare hits line zero. The two
    // writes to unknown indexes must have no effect at all.
    write_reg(lsms_pkg::REG_FRAME_SKIP, 8'd1);
    write_reg(lsms_pkg::REG_STAT_IRQ_EN, 8'hFF);
    write_reg(lsms_pkg::REG_LINE_COMPARE, 8'd0);
    write_reg(8'd4, 8'h00);
    write_reg(8'hFF, 8'hFF);
    tick_pending_q = '{1'b1, 1'b0, 1'b1, 1'b0};
    drain();

    // Hblank and OAM requests only, with a compare that can never match.
    write_reg(lsms_pkg::REG_STAT_IRQ_EN, 8'h05);
    write_reg(lsms_pkg::REG_LINE_COMPARE, 8'd255);
    tick_pending_q = '{1'b0, 1'b1, 1'b1, 1'b0};
    drain();

    // Display off through a wide write whose enable bit is clear, then back
    // on: the counter restarts so the first line seen is line one, which
    // here raises the coincidence interrupt on its own.
    write_reg(lsms_pkg::REG_LCD_ENABLE, 8'hFE);
    tick_pending_q = '{1'b1, 1'b0, 1'b0, 1'b1};
    drain();
    write_reg(lsms_pkg::REG_LCD_ENABLE, 8'h01);
    write_reg(lsms_pkg::REG_LINE_COMPARE, 8'd1);
    write_reg(lsms_pkg::REG_STAT_IRQ_EN, 8'h08);
    tick_pending_q = '{1'b0, 1'b1, 1'b0};
    drain();

    // Random part: short stretches under random settings, each one starting
    // only once the previous one has fully drained.
    repeat (3) begin
      shuffle_regs(1'b0);
      run_lines($urandom_range(8, 16), 1'b0);
    end

    // More than a full frame with the display on, so that from wherever the
    // counter stands this goes through the first vblank line, the final line
    // and the wrap to line zero with its frame decision. The compare is put
    // on one of the vblank lines. The first half runs without any idling.
    shuffle_regs(1'b1);
    case ($urandom_range(2))
      0:       write_reg(lsms_pkg::REG_LINE_COMPARE, lsms_pkg::FIRST_VBLANK_LINE);
      1:       write_reg(lsms_pkg::REG_LINE_COMPARE, 8'(FRAME_LINES - 1));
      default: write_reg(lsms_pkg::REG_LINE_COMPARE, 8'($urandom_range(145, 152)));
    endcase
    write_reg(lsms_pkg::REG_FRAME_SKIP, 8'($urandom_range(2)));
    run_lines(80, 1'b1);
    run_lines(80, 1'b0);

    // Extremes of the registers.
    write_reg(lsms_pkg::REG_LCD_ENABLE, 8'hFF);
    write_reg(lsms_pkg::REG_LINE_COMPARE, 8'hFF);
    write_reg(lsms_pkg::REG_STAT_IRQ_EN, 8'h00);
    write_reg(lsms_pkg::REG_FRAME_SKIP, 8'hFF);
    run_lines(10, 1'b0);

    // Everything has arrived; give the block a quiet tail in which any
    // stray phase result would be caught by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog: a run in which nothing moves on any channel for this long has
  // hung, whether a tick is never taken or an expected phase never comes.
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lsms_pkg.sv
hdl/lsms_if.sv
hdl/lcd_scanline_mode_sequencer_top.sv
dv/tb.sv
